FILE: rtl/median_of_7_filter_defines.svh
// Assertion macros used by the median filter front end (mo7_front).
`ifndef MEDIAN_OF_7_FILTER_DEFINES_SVH
`define MEDIAN_OF_7_FILTER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define MO7_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define MO7_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mo7_pkg.sv
// Shared types and constants of the seven-tap median filter.
`default_nettype none

package mo7_pkg;

  localparam int WIN_LEN    = 7;        // samples in one window
  localparam int HIST_LEN   = 6;        // samples kept in the history cells
  localparam int MED_IDX    = 3;        // middle slot of the sorted window
  localparam int NUM_ROUNDS = WIN_LEN;  // odd-even transposition rounds

  typedef logic [1:0] cnt_t;

  localparam cnt_t CNT_ZERO    = 2'd0;
  localparam cnt_t CNT_FULL    = 2'd3;  // three samples taken: windows now yield medians
  localparam cnt_t FLUSH_FIRST = 2'd1;
  localparam cnt_t FLUSH_MID   = 2'd2;
  localparam cnt_t FLUSH_LAST  = 2'd3;

  // Control that travels with each window down the sorter.
  typedef struct packed {
    logic valid;
    logic final_res;
  } win_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mo7_if.sv
// Valid/ready channel interfaces for samples in and medians out.
`default_nettype none

interface mo7_sample_if #(parameter int SAMPLE_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;

  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface mo7_median_if #(parameter int SAMPLE_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;
  logic                          final_res;

  modport source (output valid, median, final_res, input ready);
  modport sink   (input valid, median, final_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/mo7_cas.sv
// Compare-exchange cell: signed min to lo, max to hi.
`default_nettype none

module mo7_cas #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic [SAMPLE_BITS-1:0] a,
  input  wire logic [SAMPLE_BITS-1:0] b,
  output logic      [SAMPLE_BITS-1:0] lo,
  output logic      [SAMPLE_BITS-1:0] hi
);

  logic swap;

  assign swap = $signed(b) < $signed(a);
  assign lo   = swap ? b : a;
  assign hi   = swap ? a : b;

endmodule

`default_nettype wire

FILE: rtl/mo7_stage.sv
// One registered round of the odd-even transposition sorter.
`default_nettype none

module mo7_stage
  import mo7_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int PARITY      = 0
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire win_ctl_t                            up_ctl,
  input  wire logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] up_data,
  output logic                                     up_ready,
  output win_ctl_t                                 dn_ctl,
  output logic      [WIN_LEN-1:0][SAMPLE_BITS-1:0] dn_data,
  input  wire logic                                dn_ready
);

  logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] swapped;
  logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] data;
  logic                                valid;
  logic                                final_res;

  // Pair (i, i+1) for every i of this round's parity; unpaired ends pass.
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_slot
    localparam bit IS_LO = (i >= PARITY) && (((i - PARITY) % 2) == 0) && (i + 1 < WIN_LEN);
    localparam bit IS_HI = (i - 1 >= PARITY) && (((i - 1 - PARITY) % 2) == 0);
    if (IS_LO) begin : g_cell
      mo7_cas #(.SAMPLE_BITS(SAMPLE_BITS)) u_cas (
        .a  (up_data[i]),
        .b  (up_data[i+1]),
        .lo (swapped[i]),
        .hi (swapped[i+1])
      );
    end else if (!IS_HI) begin : g_pass
      assign swapped[i] = up_data[i];
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_ctl.valid;
    end
    if (up_ready && up_ctl.valid) begin
      data      <= swapped;
      final_res <= up_ctl.final_res;
    end
  end

  assign dn_ctl.valid     = valid;
  assign dn_ctl.final_res = final_res;
  assign dn_data          = data;

endmodule

`default_nettype wire

FILE: rtl/mo7_front.sv
// Window history cells with edge replication and end-of-stream flush.
`default_nettype none

module mo7_front
  import mo7_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mo7_sample_if.sink                               sample_stream,
  input  wire logic                                take,
  output win_ctl_t                                 win_ctl,
  output logic      [WIN_LEN-1:0][SAMPLE_BITS-1:0] win_data
);

`include "median_of_7_filter_defines.svh"

  logic [HIST_LEN-1:0][SAMPLE_BITS-1:0] hist;
  logic [HIST_LEN-1:0][SAMPLE_BITS-1:0] base;
  logic [SAMPLE_BITS-1:0]               hold;
  logic [SAMPLE_BITS-1:0]               newest;
  logic [SAMPLE_BITS-1:0]               s;
  cnt_t                                 cnt;
  cnt_t                                 step_k;
  logic                                 flushing;
  logic                                 acc;
  logic                                 eos;
  logic                                 emit_k;
  logic                                 adv_flush;

  assign s   = sample_stream.sample;
  assign eos = sample_stream.end_of_stream;

  assign sample_stream.ready = !flushing && take;
  assign acc = sample_stream.valid && sample_stream.ready;

  // Flush step k covers a position only if k + cnt reaches three.
  assign emit_k = flushing && ((step_k == FLUSH_LAST) ||
                               ((step_k == FLUSH_MID) && (cnt != CNT_ZERO)) ||
                               ((step_k == FLUSH_FIRST) && cnt[1]));
  assign adv_flush = flushing && (!emit_k || take);

  // First sample of a stream stands in for all earlier positions.
  always_comb begin
    if (flushing) begin
      base   = hist;
      newest = hold;
    end else begin
      base   = (cnt == CNT_ZERO) ? {HIST_LEN{s}} : hist;
      newest = s;
    end
  end

  assign win_data[HIST_LEN-1:0] = base;
  assign win_data[WIN_LEN-1]    = newest;
  assign win_ctl.valid          = flushing ? emit_k : (acc && (cnt == CNT_FULL));
  assign win_ctl.final_res      = flushing && (step_k == FLUSH_LAST);

  always_ff @(posedge clk) begin
    if (acc || adv_flush) begin
      hist[HIST_LEN-2:0] <= base[HIST_LEN-1:1];
      hist[HIST_LEN-1]   <= newest;
    end
    if (acc && eos) begin
      hold <= s;
    end
    if (rst) begin
      cnt      <= CNT_ZERO;
      step_k   <= FLUSH_FIRST;
      flushing <= 1'b0;
    end else if (acc) begin
      if (eos) begin
        flushing <= 1'b1;
        step_k   <= FLUSH_FIRST;
      end else if (cnt != CNT_FULL) begin
        cnt <= cnt + 2'd1;
      end
    end else if (adv_flush) begin
      if (step_k == FLUSH_LAST) begin
        flushing <= 1'b0;
        cnt      <= CNT_ZERO;
      end else begin
        step_k <= step_k + 2'd1;
      end
    end
  end

  `MO7_ASSERT_NEXT(a_eos_starts_flush, !rst && acc && eos, flushing && (step_k == FLUSH_FIRST) && (hold == $past(s)), "end of stream did not start a flush")
  `MO7_ASSERT_NEXT(a_flush_ends_clean, !rst && adv_flush && (step_k == FLUSH_LAST), !flushing && (cnt == CNT_ZERO), "flush did not return to a fresh stream")
  `MO7_ASSERT_NEXT(a_count_steps, !rst && acc && !eos && (cnt != CNT_FULL), cnt == $past(cnt) + 2'd1, "sample count did not advance")

endmodule

`default_nettype wire

FILE: rtl/median_of_7_filter.sv
// A median is formed when the sample three positions on is taken, then passes the sorter rounds.
// Throughput: one sample per cycle when not stalled; an end-of-stream sample holds off input
//   while it flushes; its window and the flush windows (up to four results) go out one per cycle.
// The sorter is seven registered odd-even compare-exchange rounds; the last is the output reg.
// Reset (rst, synchronous) empties the sorter and starts a new stream; history needs no clear.
`default_nettype none

module median_of_7_filter
  import mo7_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mo7_sample_if.sink   sample_stream,
  mo7_median_if.source median_stream
);

  // Stage r reads slot r and writes slot r + 1; slot 0 comes from the history
  // cells, the last slot is the output register.
  win_ctl_t                            ctl  [NUM_ROUNDS+1];
  logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] data [NUM_ROUNDS+1];
  logic [NUM_ROUNDS:0]                 rdy;

  // History cells: six samples shift by one per request or flush step; the
  // newest sample (or the held end sample while flushing) completes the window.
  mo7_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_stream (sample_stream),
    .take          (rdy[0]),
    .win_ctl       (ctl[0]),
    .win_data      (data[0])
  );

  // Seven rounds sort seven values; each round is a row of compare-exchange
  // cells with its own valid bit, so a stall only fills bubbles behind it.
  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    mo7_stage #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PARITY      (r % 2)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_ctl   (ctl[r]),
      .up_data  (data[r]),
      .up_ready (rdy[r]),
      .dn_ctl   (ctl[r+1]),
      .dn_data  (data[r+1]),
      .dn_ready (rdy[r+1])
    );
  end

  assign rdy[NUM_ROUNDS] = median_stream.ready;

  // Middle of the sorted window is the median.
  assign median_stream.valid     = ctl[NUM_ROUNDS].valid;
  assign median_stream.final_res = ctl[NUM_ROUNDS].final_res;
  assign median_stream.median    = data[NUM_ROUNDS][MED_IDX];

endmodule

`default_nettype wire
